/* sv/ple_pkg.sv */
// Shared types and constants of the positional list engine.
package ple_pkg;

  localparam int DefCapacity = 32;

  localparam int OpcodeW   = 3;
  localparam int ValueW    = 32;
  localparam int PositionW = 6;
  localparam int StatusW   = 3;
  localparam int IndexW    = 5;
  localparam int CountW    = 6;

  typedef enum logic [OpcodeW-1:0] {
    OpInsFront = 3'd0,
    OpInsBack  = 3'd1,
    OpInsAt    = 3'd2,
    OpDelFront = 3'd3,
    OpDelBack  = 3'd4,
    OpDelAt    = 3'd5
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StBadIndex = 3'd1,
    StUnderflow = 3'd2,
    StFull     = 3'd3,
    StBadOp    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StateIdle,
    StateShift,
    StateFlush,
    StatePut,
    StateEmit
  } state_e;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic               has_element;
    logic [IndexW-1:0]  element_index;
    logic [CountW-1:0]  count;
    logic               last;
  } emit_t;

endpackage

/* sv/positional_list_engine.sv */
// Positional list engine top level: storage, sequencer and result register.
// One request is taken when start is high and busy is low. A rejected
// request, or one that leaves the list empty, gives one result on the
// next cycle. Any other request first shifts the stored entries through
// the storage memory, one entry per cycle over its single read and single
// write port (count minus position moves for an insert, count minus
// position minus one for a delete), then passes a flush state after any
// shift and a put state to write an inserted value, and then reads the
// list out one element per cycle. The next request can be taken in the
// same cycle as the last result of a request appears. Results appear on
// consecutive cycles, in the cycle after each storage read, each marked
// by valid_o for one cycle; the receiver must take them as they come.
module positional_list_engine import ple_pkg::*; #(
  parameter int Capacity = DefCapacity
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [OpcodeW-1:0]         opcode_i,
  input  logic signed [ValueW-1:0]   value_i,
  input  logic [PositionW-1:0]       position_i,
  output logic                       valid_o,
  output logic [StatusW-1:0]         status_o,
  output logic                       has_element_o,
  output logic [IndexW-1:0]          element_index_o,
  output logic signed [ValueW-1:0]   element_o,
  output logic [CountW-1:0]          count_o,
  output logic                       last_o
);

  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);

  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [ValueW-1:0] wdata;
  logic              re;
  logic [IdxW-1:0]   raddr;
  logic [ValueW-1:0] rdata;
  emit_t             emit_d, emit_q;

  ple_ctrl #(
    .Capacity (Capacity),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .emit_o     (emit_d)
  );

  ple_ram #(
    .Depth (Capacity),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result stage lines up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= '0;
    end else begin
      emit_q <= emit_d;
    end
  end

  assign valid_o         = emit_q.valid;
  assign status_o        = emit_q.status;
  assign has_element_o   = emit_q.has_element;
  assign element_index_o = emit_q.element_index;
  assign count_o         = emit_q.count;
  assign last_o          = emit_q.last;
  assign element_o       = emit_q.has_element ? rdata : '0;

  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("result stream broken before last transfer");

  a_busy_while_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("request accepted in the middle of a result stream");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != StOk) |-> last_o && !has_element_o)
    else $error("error result carries an element or is not last");

  a_element_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_element_o |-> (status_o == StOk))
    else $error("element transfer with error status");

endmodule

/* sv/ple_ram.sv */
// Single-port-write, single-port-read list storage with registered read data.
module ple_ram import ple_pkg::*; #(
  parameter int Depth = DefCapacity,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem [Depth];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ple_ctrl.sv */
// Request check, shift sequencer and list readout control.
module ple_ctrl import ple_pkg::*; #(
  parameter int Capacity = DefCapacity,
  parameter int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1,
  parameter int CntW     = $clog2(Capacity + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [OpcodeW-1:0]   opcode_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [PositionW-1:0] position_i,
  output logic                 we_o,
  output logic [IdxW-1:0]      waddr_o,
  output logic [ValueW-1:0]    wdata_o,
  output logic                 re_o,
  output logic [IdxW-1:0]      raddr_o,
  input  logic [ValueW-1:0]    rdata_i,
  output emit_t                emit_o
);

  localparam int CmpW = (CntW > PositionW + 1) ? CntW : PositionW + 1;

  state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   moves_q, moves_d;
  logic [IdxW-1:0]   src_q, src_d;
  logic [IdxW-1:0]   dst_q, dst_d;
  logic [IdxW-1:0]   at_q, at_d;
  logic [IdxW-1:0]   e_q, e_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              is_ins_q, is_ins_d;
  logic              wpend_q, wpend_d;
  logic [IdxW-1:0]   wdst_q, wdst_d;

  logic            accept;
  logic            req_ins;
  status_e         req_status;
  logic [CmpW-1:0] n_ext;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] req_at;
  logic [CmpW-1:0] req_moves;
  logic [CntW-1:0] req_count;
  logic            emit_last;

  assign busy   = (state_q != StateIdle);
  assign accept = start && !busy;
  assign n_ext  = CmpW'(count_q);
  assign pos_ext = CmpW'(position_i);
  assign emit_last = ((CntW'(e_q) + CntW'(1)) == count_q);

  // request check
  always_comb begin
    req_ins    = 1'b0;
    req_at     = '0;
    req_status = StOk;
    unique case (opcode_i)
      OpInsFront: begin
        req_ins = 1'b1;
        req_at  = '0;
      end
      OpInsBack: begin
        req_ins = 1'b1;
        req_at  = n_ext;
      end
      OpInsAt: begin
        req_ins = 1'b1;
        req_at  = pos_ext;
      end
      OpDelFront: req_at = '0;
      OpDelBack:  req_at = n_ext - CmpW'(1);
      OpDelAt:    req_at = pos_ext;
      default:    req_status = StBadOp;
    endcase
    if (req_status != StBadOp) begin
      if (req_ins) begin
        if (req_at > n_ext) begin
          req_status = StBadIndex;
        end else if (n_ext == CmpW'(Capacity)) begin
          req_status = StFull;
        end
      end else begin
        if (count_q == '0) begin
          req_status = StUnderflow;
        end else if (req_at >= n_ext) begin
          req_status = StBadIndex;
        end
      end
    end
    if (req_ins) begin
      req_moves = n_ext - req_at;
      req_count = count_q + CntW'(1);
    end else begin
      req_moves = n_ext - req_at - CmpW'(1);
      req_count = count_q - CntW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: begin
        if (accept && req_status == StOk) begin
          if (req_moves != '0) begin
            state_d = StateShift;
          end else if (req_ins) begin
            state_d = StatePut;
          end else if (req_count != '0) begin
            state_d = StateEmit;
          end
        end
      end
      StateShift: begin
        if (moves_q == CntW'(1)) begin
          state_d = StateFlush;
        end
      end
      StateFlush: state_d = is_ins_q ? StatePut : StateEmit;
      StatePut:   state_d = StateEmit;
      StateEmit: begin
        if (emit_last) begin
          state_d = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  // datapath registers
  always_comb begin
    count_d = count_q;
    moves_d = moves_q;
    src_d   = src_q;
    dst_d   = dst_q;
    at_d    = at_q;
    e_d     = e_q;
    value_d = value_q;
    is_ins_d = is_ins_q;
    wpend_d = (state_q == StateShift);
    wdst_d  = dst_q;
    case (state_q)
      StateIdle: begin
        e_d = '0;
        if (accept && req_status == StOk) begin
          count_d  = req_count;
          moves_d  = CntW'(req_moves);
          at_d     = IdxW'(req_at);
          value_d  = value_i;
          is_ins_d = req_ins;
          if (req_ins) begin
            dst_d = IdxW'(n_ext);
            src_d = IdxW'(n_ext - CmpW'(1));
          end else begin
            dst_d = IdxW'(req_at);
            src_d = IdxW'(req_at + CmpW'(1));
          end
        end
      end
      StateShift: begin
        moves_d = moves_q - CntW'(1);
        if (is_ins_q) begin
          src_d = src_q - IdxW'(1);
          dst_d = dst_q - IdxW'(1);
        end else begin
          src_d = src_q + IdxW'(1);
          dst_d = dst_q + IdxW'(1);
        end
      end
      StateEmit: e_d = e_q + IdxW'(1);
      default: ;
    endcase
  end

  // memory port and readout outputs
  always_comb begin
    we_o    = wpend_q || (state_q == StatePut);
    waddr_o = wpend_q ? wdst_q : at_q;
    wdata_o = wpend_q ? rdata_i : value_q;
    re_o    = 1'b0;
    raddr_o = src_q;
    emit_o  = '0;
    unique case (state_q)
      StateIdle: begin
        if (accept && (req_status != StOk || req_count == '0)) begin
          emit_o.valid  = 1'b1;
          emit_o.status = req_status;
          emit_o.count  = (req_status == StOk) ? '0 : CountW'(count_q);
          emit_o.last   = 1'b1;
        end
      end
      StateShift: re_o = 1'b1;
      StateEmit: begin
        re_o    = 1'b1;
        raddr_o = e_q;
        emit_o.valid         = 1'b1;
        emit_o.status        = StOk;
        emit_o.has_element   = 1'b1;
        emit_o.element_index = IndexW'(e_q);
        emit_o.count         = CountW'(count_q);
        emit_o.last          = emit_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      count_q <= '0;
      moves_q <= '0;
      wpend_q <= 1'b0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      moves_q <= moves_d;
      wpend_q <= wpend_d;
      e_q     <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    at_q     <= at_d;
    value_q  <= value_d;
    is_ins_q <= is_ins_d;
    wdst_q   <= wdst_d;
  end

endmodule
